### rtl/fom_pkg.sv
// shared types, codes and sizes of the fifo order matcher
`default_nettype none

package fom_pkg;

   localparam int QTY_W   = 16;
   localparam int PRICE_W = 24;

   // request codes as seen on req_type
   localparam logic [1:0] REQ_PLACE_BUY  = 2'd0;
   localparam logic [1:0] REQ_PLACE_SELL = 2'd1;
   localparam logic [1:0] REQ_MATCH      = 2'd2;
   localparam logic [1:0] REQ_UNUSED     = 2'd3;

   // result kinds
   localparam logic [1:0] RES_ACCEPT = 2'd0;
   localparam logic [1:0] RES_REJECT = 2'd1;
   localparam logic [1:0] RES_MATCH  = 2'd2;
   localparam logic [1:0] RES_DONE   = 2'd3;

   // order book sizing
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int MAX_RESULTS         = 32;
   localparam int MAX_MATCHES         = MAX_RESULTS - 1;
   localparam int MATCH_CNT_W         = $clog2(MAX_RESULTS);

   // command queue between front and engine
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   typedef struct packed {
      logic [1:0]         op;
      logic [QTY_W-1:0]   qty;
      logic [PRICE_W-1:0] price;
   } cmd_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } order_entry_type;

endpackage

`default_nettype wire

### rtl/fom_front.sv
// request intake: classifies requests and drops unused codes
`default_nettype none

module fom_front
   import fom_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_type,
   input  wire logic [QTY_W-1:0]   req_order_quantity,
   input  wire logic [PRICE_W-1:0] req_order_price,
   input  wire logic               q_full,
   output logic                    q_push,
   output cmd_type                 q_push_cmd
);

   logic unused_seen_ff;
   logic unused_seen_in;
   logic is_unused;

   always_comb begin
      is_unused = 1'b0;
      unique case (req_type)
         REQ_PLACE_BUY, REQ_PLACE_SELL, REQ_MATCH: is_unused = 1'b0;
         default: is_unused = 1'b1;
      endcase
   end

   // unused codes are swallowed, but still wait for room so order is kept simple
   assign req_ready         = !q_full;
   assign q_push            = req_valid && !q_full && !is_unused;
   assign q_push_cmd.op     = req_type;
   assign q_push_cmd.qty    = req_order_quantity;
   assign q_push_cmd.price  = req_order_price;

   // sticky flag of a dropped request, kept as a debug observable
   assign unused_seen_in = unused_seen_ff || (req_valid && !q_full && is_unused);

   always_ff @(posedge clock) begin
      if (reset) begin
         unused_seen_ff <= 1'b0;
      end else begin
         unused_seen_ff <= unused_seen_in;
      end
   end

endmodule

`default_nettype wire

### rtl/fom_cmd_queue.sv
// short command queue between the intake and the matching engine
`default_nettype none

module fom_cmd_queue
   import fom_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_cmd,
   output logic      full,
   input  wire logic pop,
   output logic      head_valid,
   output cmd_type   head_cmd
);

   cmd_type                 slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff;
   logic [CMDQ_PTR_W-1:0]   wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff;
   logic [CMDQ_CNT_W-1:0]   count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full       = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/fom_engine.sv
// matching engine: buy and sell ring buffers, match sequencer, output register
`default_nettype none

module fom_engine
   import fom_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  cmd_type                 cmd,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_result_kind,
   output logic [QTY_W-1:0]        rsp_match_quantity,
   output logic [PRICE_W-1:0]      rsp_match_price,
   output logic                    rsp_stopped_on_empty,
   output logic                    rsp_last
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_STEP = 2'd2;

   order_entry_type buy_mem  [QUEUE_DEPTH];
   order_entry_type sell_mem [QUEUE_DEPTH];
   order_entry_type buy_rd_ff;
   order_entry_type sell_rd_ff;

   logic [1:0]             state_ff;
   logic [1:0]             state_in;
   logic [PTR_W-1:0]       buy_head_ff;
   logic [PTR_W-1:0]       buy_head_in;
   logic [PTR_W-1:0]       sell_head_ff;
   logic [PTR_W-1:0]       sell_head_in;
   logic [CNT_W-1:0]       buy_count_ff;
   logic [CNT_W-1:0]       buy_count_in;
   logic [CNT_W-1:0]       sell_count_ff;
   logic [CNT_W-1:0]       sell_count_in;
   logic [MATCH_CNT_W-1:0] match_cnt_ff;
   logic [MATCH_CNT_W-1:0] match_cnt_in;

   logic                   buy_wr_en;
   logic [PTR_W-1:0]       buy_wr_addr;
   order_entry_type        buy_wr_data;
   logic                   sell_wr_en;
   logic [PTR_W-1:0]       sell_wr_addr;
   order_entry_type        sell_wr_data;

   logic [SUM_W-1:0]       buy_sum;
   logic [SUM_W-1:0]       sell_sum;
   logic [PTR_W-1:0]       buy_tail;
   logic [PTR_W-1:0]       sell_tail;
   logic                   buy_full;
   logic                   sell_full;
   logic                   both_nonempty;
   logic                   prices_cross;
   logic                   at_limit;
   logic [QTY_W-1:0]       trade_qty;
   logic [QTY_W-1:0]       buy_left;
   logic [QTY_W-1:0]       sell_left;

   logic                   out_ok;
   logic                   emit;
   logic [1:0]             emit_kind;
   logic [QTY_W-1:0]       emit_qty;
   logic [PRICE_W-1:0]     emit_price;
   logic                   emit_empty;
   logic                   emit_last;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_kind_ff;
   logic [QTY_W-1:0]       rsp_qty_ff;
   logic [PRICE_W-1:0]     rsp_price_ff;
   logic                   rsp_empty_ff;
   logic                   rsp_last_ff;

   // ring tail: head + count folded once, the sum stays below twice the depth
   assign buy_sum   = SUM_W'(buy_head_ff) + SUM_W'(buy_count_ff);
   assign sell_sum  = SUM_W'(sell_head_ff) + SUM_W'(sell_count_ff);
   assign buy_tail  = (buy_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(buy_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(buy_sum);
   assign sell_tail = (sell_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(sell_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(sell_sum);
   assign buy_full  = (buy_count_ff == CNT_W'(QUEUE_DEPTH));
   assign sell_full = (sell_count_ff == CNT_W'(QUEUE_DEPTH));

   assign both_nonempty = (buy_count_ff != '0) && (sell_count_ff != '0);
   assign prices_cross  = (buy_rd_ff.price >= sell_rd_ff.price);
   assign at_limit      = (match_cnt_ff == MATCH_CNT_W'(MAX_MATCHES));
   assign trade_qty     = (buy_rd_ff.qty < sell_rd_ff.qty) ? buy_rd_ff.qty : sell_rd_ff.qty;
   assign buy_left      = buy_rd_ff.qty - trade_qty;
   assign sell_left     = sell_rd_ff.qty - trade_qty;

   assign out_ok = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      buy_head_in   = buy_head_ff;
      sell_head_in  = sell_head_ff;
      buy_count_in  = buy_count_ff;
      sell_count_in = sell_count_ff;
      match_cnt_in  = match_cnt_ff;
      cmd_pop       = 1'b0;
      buy_wr_en     = 1'b0;
      buy_wr_addr   = buy_tail;
      buy_wr_data   = '{price: cmd.price, qty: cmd.qty};
      sell_wr_en    = 1'b0;
      sell_wr_addr  = sell_tail;
      sell_wr_data  = '{price: cmd.price, qty: cmd.qty};
      emit          = 1'b0;
      emit_kind     = RES_ACCEPT;
      emit_qty      = '0;
      emit_price    = '0;
      emit_empty    = 1'b0;
      emit_last     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  REQ_PLACE_BUY: begin
                     if (out_ok) begin
                        cmd_pop   = 1'b1;
                        emit      = 1'b1;
                        emit_kind = buy_full ? RES_REJECT : RES_ACCEPT;
                        buy_wr_en = !buy_full;
                        if (!buy_full) begin
                           buy_count_in = buy_count_ff + 1'b1;
                        end
                     end
                  end
                  REQ_PLACE_SELL: begin
                     if (out_ok) begin
                        cmd_pop    = 1'b1;
                        emit       = 1'b1;
                        emit_kind  = sell_full ? RES_REJECT : RES_ACCEPT;
                        sell_wr_en = !sell_full;
                        if (!sell_full) begin
                           sell_count_in = sell_count_ff + 1'b1;
                        end
                     end
                  end
                  REQ_MATCH: begin
                     cmd_pop      = 1'b1;
                     match_cnt_in = '0;
                     state_in     = S_READ;
                  end
                  default: begin
                     // unused codes never reach the queue; drain defensively
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            // head entries land in the read registers at this edge
            state_in = S_STEP;
         end
         S_STEP: begin
            if (out_ok) begin
               emit = 1'b1;
               if (both_nonempty && !at_limit && prices_cross) begin
                  emit_kind    = RES_MATCH;
                  emit_qty     = trade_qty;
                  emit_price   = sell_rd_ff.price;
                  emit_last    = 1'b0;
                  match_cnt_in = match_cnt_ff + 1'b1;
                  buy_wr_en    = 1'b1;
                  buy_wr_addr  = buy_head_ff;
                  buy_wr_data  = '{price: buy_rd_ff.price, qty: buy_left};
                  sell_wr_en   = 1'b1;
                  sell_wr_addr = sell_head_ff;
                  sell_wr_data = '{price: sell_rd_ff.price, qty: sell_left};
                  if (buy_left == '0) begin
                     buy_head_in  = (buy_head_ff == PTR_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : buy_head_ff + 1'b1;
                     buy_count_in = buy_count_ff - 1'b1;
                  end
                  if (sell_left == '0) begin
                     sell_head_in  = (sell_head_ff == PTR_W'(QUEUE_DEPTH - 1)) ?
                                     '0 : sell_head_ff + 1'b1;
                     sell_count_in = sell_count_ff - 1'b1;
                  end
                  state_in = S_READ;
               end else begin
                  emit_kind  = RES_DONE;
                  emit_empty = !both_nonempty;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         buy_head_ff   <= '0;
         sell_head_ff  <= '0;
         buy_count_ff  <= '0;
         sell_count_ff <= '0;
         match_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         buy_head_ff   <= buy_head_in;
         sell_head_ff  <= sell_head_in;
         buy_count_ff  <= buy_count_in;
         sell_count_ff <= sell_count_in;
         match_cnt_ff  <= match_cnt_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff  <= emit_kind;
         rsp_qty_ff   <= emit_qty;
         rsp_price_ff <= emit_price;
         rsp_empty_ff <= emit_empty;
         rsp_last_ff  <= emit_last;
      end
   end

   // order memories, one write and one registered read port each
   always_ff @(posedge clock) begin
      if (buy_wr_en) begin
         buy_mem[buy_wr_addr] <= buy_wr_data;
      end
      buy_rd_ff <= buy_mem[buy_head_ff];
   end

   always_ff @(posedge clock) begin
      if (sell_wr_en) begin
         sell_mem[sell_wr_addr] <= sell_wr_data;
      end
      sell_rd_ff <= sell_mem[sell_head_ff];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = rsp_kind_ff;
   assign rsp_match_quantity   = rsp_qty_ff;
   assign rsp_match_price      = rsp_price_ff;
   assign rsp_stopped_on_empty = rsp_empty_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/fifo_order_matcher.sv
// top level of the fifo order matcher: intake, command queue, matching engine
//
// usage
//   req channel (valid/ready): one request per handshake. req_type 0 places a
//   buy order, 1 a sell order, 2 runs matching, 3 is dropped with no result.
//   rsp channel (valid/ready): results in order; rsp_last marks the final
//   result of a request. a place request gives one result (accepted or
//   rejected when its queue is full). a matching request gives up to 31
//   match results then one done result carrying stopped_on_empty.
//   a taken place request is written into the command queue, and the engine
//   then registers its result in the output register; place requests can
//   follow one per cycle when nothing stalls. each match is a head read,
//   then a compare and update of both queue heads.
//   the two-entry command queue lets requests enter while the engine works.
//   when the receiver stalls, the output register holds its result and the
//   engine waits; requests keep entering until the command queue fills.
//   reset (synchronous) empties both order queues and the command queue;
//   the order memories themselves are not cleared.
`default_nettype none

module fifo_order_matcher
   import fom_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_type,
   input  wire logic [QTY_W-1:0]   req_order_quantity,
   input  wire logic [PRICE_W-1:0] req_order_price,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_result_kind,
   output logic [QTY_W-1:0]        rsp_match_quantity,
   output logic [PRICE_W-1:0]      rsp_match_price,
   output logic                    rsp_stopped_on_empty,
   output logic                    rsp_last
);

   // front to queue
   logic    q_full;
   logic    q_push;
   cmd_type q_push_cmd;

   // queue to engine
   logic    q_head_valid;
   cmd_type q_head_cmd;
   logic    q_pop;

   // intake classifies requests and drops unused codes
   fom_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_order_quantity (req_order_quantity),
      .req_order_price    (req_order_price),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_push_cmd         (q_push_cmd)
   );

   // decouples intake from the engine
   fom_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd)
   );

   // order rings, matching sequencer and result register
   fom_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_engine (
      .clock                (clock),
      .reset                (reset),
      .cmd_valid            (q_head_valid),
      .cmd                  (q_head_cmd),
      .cmd_pop              (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_match_quantity   (rsp_match_quantity),
      .rsp_match_price      (rsp_match_price),
      .rsp_stopped_on_empty (rsp_stopped_on_empty),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire
